>>> rtl/core/hcbb_pkg.sv
// Shared types, constants and channel lookup functions for the colour blob box block.
package hcbb_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam logic [12:0] RECIP_FIVE = 13'd6554;
  localparam logic [8:0] HUE_WRAP = 9'd360;
  localparam logic [8:0] SEXTANT_G = 9'd200;
  localparam logic [8:0] SEXTANT_B = 9'd400;

  localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TARGET_HUE = 3'd2;
  localparam logic [2:0] REG_MIN_SATURATION = 3'd3;
  localparam logic [2:0] REG_MIN_VALUE = 3'd4;
  localparam logic [2:0] REG_HUE_THRESHOLD = 3'd5;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [8:0]  target_hue;
    logic [6:0]  min_saturation;
    logic [6:0]  min_value;
    logic [8:0]  hue_threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_DIV,
    FS_SCALE,
    FS_CMP,
    FS_PUSH
  } front_state_t;

  // The loops unroll into constant lookup tables.
  function automatic logic [6:0] pct5(input logic [4:0] c);
    logic [6:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (c == 5'(i)) p = 7'((i * 255 / 31) * 100 / 255);
    end
    return p;
  endfunction

  function automatic logic [6:0] pct6(input logic [5:0] c);
    logic [6:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (c == 6'(i)) p = 7'((i * 255 / 63) * 100 / 255);
    end
    return p;
  endfunction

endpackage

>>> rtl/core/hcbb_front.sv
// Pixel front end: RGB565 to HSV with an iterative divider and the match test.
module hcbb_front (
  input  logic              clk,
  input  logic              rst,
  input  hcbb_pkg::cfg_t    cfg,
  input  logic              pix_valid,
  output logic              pix_ready,
  input  logic [15:0]       pixel_word,
  output logic              push,
  output logic              push_match,
  input  logic              queue_full
);

  hcbb_pkg::front_state_t state, state_next;

  logic [6:0]  r, g, b, lo, hi, d;
  logic signed [7:0] n;
  logic [6:0]  n_abs;
  logic [8:0]  base_c;

  logic [13:0] rem_h, rem_s;
  logic [6:0]  den_h, den_s, q_h, q_s, val;
  logic [8:0]  base;
  logic        neg, gray;
  logic [2:0]  step;
  logic [13:0] sub_h, sub_s;

  logic signed [9:0] hue_raw;
  logic [9:0]  hue_mag;
  logic [10:0] mag3;
  logic [23:0] prod;
  logic        hneg;

  logic [8:0]  h5;
  logic signed [10:0] h_s, diff_c;
  logic signed [10:0] diff;
  logic        sat_ok, val_ok;
  logic [21:0] dsq, tsq;

  assign pix_ready = (state == hcbb_pkg::FS_IDLE);

  always_comb begin
    r = hcbb_pkg::pct5(pixel_word[15:11]);
    g = hcbb_pkg::pct6(pixel_word[10:5]);
    b = hcbb_pkg::pct5(pixel_word[4:0]);
    lo = (r < g) ? r : g;
    hi = (r > g) ? r : g;
    if (b < lo) lo = b;
    if (b > hi) hi = b;
    d = hi - lo;
    if (r == hi) begin
      n = $signed({1'b0, g}) - $signed({1'b0, b});
      base_c = 9'd0;
    end else if (g == hi) begin
      n = $signed({1'b0, b}) - $signed({1'b0, r});
      base_c = hcbb_pkg::SEXTANT_G;
    end else begin
      n = $signed({1'b0, r}) - $signed({1'b0, g});
      base_c = hcbb_pkg::SEXTANT_B;
    end
    n_abs = n[7] ? 7'(-n) : n[6:0];
  end

  assign sub_h = 14'(den_h) << step;
  assign sub_s = 14'(den_s) << step;

  always_comb begin
    hue_raw = neg ? $signed({1'b0, base}) - $signed({3'b0, q_h})
                  : $signed({1'b0, base}) + $signed({3'b0, q_h});
    hue_mag = hue_raw[9] ? 10'(-hue_raw) : hue_raw;
    mag3 = 11'(hue_mag) * 11'd3;
  end

  always_comb begin
    h5 = prod[23:15];
    h_s = hneg ? -$signed({2'b0, h5}) : $signed({2'b0, h5});
    if (h_s < 0) h_s = h_s + $signed({2'b0, hcbb_pkg::HUE_WRAP});
    if (gray) h_s = '0;
    diff_c = h_s - $signed({2'b0, cfg.target_hue});
  end

  assign dsq = 22'(diff * diff);
  assign tsq = 22'(cfg.hue_threshold) * 22'(cfg.hue_threshold);
  assign push_match = (dsq < tsq) && sat_ok && val_ok;
  assign push = (state == hcbb_pkg::FS_PUSH) && !queue_full;

  always_comb begin
    state_next = state;
    case (state)
      hcbb_pkg::FS_IDLE:  if (pix_valid) state_next = hcbb_pkg::FS_DIV;
      hcbb_pkg::FS_DIV:   if (step == 3'd0) state_next = hcbb_pkg::FS_SCALE;
      hcbb_pkg::FS_SCALE: state_next = hcbb_pkg::FS_CMP;
      hcbb_pkg::FS_CMP:   state_next = hcbb_pkg::FS_PUSH;
      hcbb_pkg::FS_PUSH:  if (!queue_full) state_next = hcbb_pkg::FS_IDLE;
      default:            state_next = hcbb_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcbb_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      hcbb_pkg::FS_IDLE: begin
        rem_h <= 14'(n_abs) * 14'd100;
        rem_s <= 14'(d) * 14'd100;
        den_h <= d;
        den_s <= hi;
        q_h <= '0;
        q_s <= '0;
        val <= hi;
        base <= base_c;
        neg <= n[7];
        gray <= (d == 7'd0);
        step <= 3'd6;
      end
      hcbb_pkg::FS_DIV: begin
        if (rem_h >= sub_h) begin
          rem_h <= rem_h - sub_h;
          q_h[step] <= 1'b1;
        end
        if (rem_s >= sub_s) begin
          rem_s <= rem_s - sub_s;
          q_s[step] <= 1'b1;
        end
        step <= step - 3'd1;
      end
      hcbb_pkg::FS_SCALE: begin
        prod <= 24'(mag3) * 24'(hcbb_pkg::RECIP_FIVE);
        hneg <= hue_raw[9];
      end
      hcbb_pkg::FS_CMP: begin
        diff <= diff_c;
        sat_ok <= !gray && (q_s > cfg.min_saturation);
        val_ok <= val > cfg.min_value;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/hcbb_queue.sv
// Short queue of match flags between the front end and the box accumulator.
module hcbb_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic push_data,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output logic pop_data
);

  localparam int unsigned AW = hcbb_pkg::QUEUE_AW;

  logic [hcbb_pkg::QUEUE_DEPTH-1:0] mem;
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;

  assign full = (count == (AW+1)'(hcbb_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !pop_valid))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(hcbb_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

>>> rtl/core/hcbb_back.sv
// Box accumulator: raster position, extremes of matching pixels and the result register.
module hcbb_back #(
  parameter int unsigned MAX_WIDTH = hcbb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = hcbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic           clk,
  input  logic           rst,
  input  hcbb_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  logic           q_match,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [71:0]    out_data,
  output logic           out_found
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned LCW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned LRW = $clog2(MAX_HEIGHT + 1);

  logic [CW-1:0]  x, gc, gc_n;
  logic [RW-1:0]  y, gr, gr_n;
  logic [LCW-1:0] lc, lc_n, w;
  logic [LRW-1:0] lr, lr_n, h;
  logic [20:0]    hits, hits_n;
  logic           fresh, col_end, row_end;
  logic [10:0]    bx, by, bw, bh;

  always_comb begin
    if (cfg.frame_width == '0) w = LCW'(1);
    else if (32'(cfg.frame_width) > MAX_WIDTH) w = LCW'(MAX_WIDTH);
    else w = LCW'(cfg.frame_width);
    if (cfg.frame_height == '0) h = LRW'(1);
    else if (32'(cfg.frame_height) > MAX_HEIGHT) h = LRW'(MAX_HEIGHT);
    else h = LRW'(cfg.frame_height);
  end

  assign q_pop = q_valid && (!out_valid || out_ready);
  assign fresh = (x == '0) && (y == '0);
  assign col_end = (LCW'(x) + LCW'(1)) >= w;
  assign row_end = (LRW'(y) + LRW'(1)) >= h;

  always_comb begin
    lc_n = fresh ? w : lc;
    lr_n = fresh ? h : lr;
    gc_n = fresh ? '0 : gc;
    gr_n = fresh ? '0 : gr;
    hits_n = fresh ? '0 : hits;
    if (q_match) begin
      hits_n = hits_n + 21'd1;
      if (LCW'(x) < lc_n) lc_n = LCW'(x);
      if (LRW'(y) < lr_n) lr_n = LRW'(y);
      if (x > gc_n) gc_n = x;
      if (y > gr_n) gr_n = y;
    end
    bx = 11'(lc_n);
    by = 11'(lr_n);
    bw = 11'(gc_n) - 11'(lc_n);
    bh = 11'(gr_n) - 11'(lr_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x <= '0;
      y <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (q_pop) begin
        if (col_end) begin
          x <= '0;
          if (row_end) begin
            y <= '0;
            out_valid <= 1'b1;
          end else begin
            y <= y + 1'b1;
          end
        end else begin
          x <= x + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      lc <= lc_n;
      lr <= lr_n;
      gc <= gc_n;
      gr <= gr_n;
      hits <= hits_n;
      if (col_end && row_end) begin
        out_data <= {7'd0, hits_n, bh, bw, by, bx};
        out_found <= (hits_n != '0);
      end
    end
  end

`ifndef SYNTHESIS
  a_frame_end_result: assert property (@(posedge clk) disable iff (rst)
    q_pop && col_end && row_end |=> out_valid)
    else $error("frame end gave no result");
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !q_pop)
    else $error("accumulator advanced while result stalled");
  a_wrap_to_origin: assert property (@(posedge clk) disable iff (rst)
    q_pop && col_end && row_end |=> (x == '0) && (y == '0))
    else $error("position did not return to frame origin");
`endif

endmodule

>>> rtl/core/hsv_color_blob_bounding_box.sv
// Top level of the colour blob bounding box block over an RGB565 pixel stream.
//
//  channel  direction  signals                         beat carries
//  s_axis   in         tvalid tready tdata[15:0]       pixel_word
//  m_axis   out        tvalid tready tdata tuser       box result, found
//  cfg      in         cfg_valid cfg_ready index data  register write
//
// A pixel passes through the front end in order: load, two restoring divisions
// on one shared step counter, yielding hue fraction and saturation, then hue
// scaling, compare and hand-off to the queue; no new pixel is taken until that hand-off.
// The accumulator takes one queued beat per cycle unless a result is stalled.
// Reset is synchronous; the configuration registers return to their default values.
module hsv_color_blob_bounding_box #(
  parameter int unsigned MAX_WIDTH = hcbb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = hcbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // pixel_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // box_x, box_y, box_w, box_h, match_count, zeros
  output logic        m_axis_tuser,   // found
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  hcbb_pkg::cfg_t cfg;
  logic push, push_match, queue_full, q_pop, q_valid, q_match;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width <= 11'd320;
      cfg.frame_height <= 11'd240;
      cfg.target_hue <= 9'd0;
      cfg.min_saturation <= 7'd0;
      cfg.min_value <= 7'd0;
      cfg.hue_threshold <= 9'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        hcbb_pkg::REG_FRAME_WIDTH:    cfg.frame_width <= cfg_data;
        hcbb_pkg::REG_FRAME_HEIGHT:   cfg.frame_height <= cfg_data;
        hcbb_pkg::REG_TARGET_HUE:     cfg.target_hue <= cfg_data[8:0];
        hcbb_pkg::REG_MIN_SATURATION: cfg.min_saturation <= cfg_data[6:0];
        hcbb_pkg::REG_MIN_VALUE:      cfg.min_value <= cfg_data[6:0];
        hcbb_pkg::REG_HUE_THRESHOLD:  cfg.hue_threshold <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  hcbb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pix_valid  (s_axis_tvalid),
    .pix_ready  (s_axis_tready),
    .pixel_word (s_axis_tdata),
    .push       (push),
    .push_match (push_match),
    .queue_full (queue_full)
  );

  hcbb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_match),
    .full      (queue_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_match)
  );

  hcbb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_match   (q_match),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_found (m_axis_tuser)
  );

endmodule

>>> test/hsv_color_blob_bounding_box_checker.sv
// Checker for the colour blob box block: predicts each frame's box and compares it with the output.
module hsv_color_blob_bounding_box_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          failures,
  output int          boxes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_W = hcbb_pkg::DEF_MAX_WIDTH;
  localparam int unsigned LIMIT_H = hcbb_pkg::DEF_MAX_HEIGHT;

  typedef struct packed {
    logic [10:0] x;
    logic [10:0] y;
    logic [10:0] w;
    logic [10:0] h;
    logic [20:0] hits;
    logic        found;
  } box_t;

  hcbb_pkg::cfg_t regs;
  int unsigned  col, row, min_col, min_row, max_col, max_row;
  logic [20:0]  hits;
  box_t         box_queue[$];

  function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit pixel_matches(input logic [15:0] word, input hcbb_pkg::cfg_t c);
    int r, g, b, lo, hi, d, hue, sat, val, diff, thr;
    r = (int'(word[15:11]) * 255 / 31) * 100 / 255;
    g = (int'(word[10:5]) * 255 / 63) * 100 / 255;
    b = (int'(word[4:0]) * 255 / 31) * 100 / 255;
    lo = (r < g) ? r : g;
    hi = (r > g) ? r : g;
    if (b < lo) lo = b;
    if (b > hi) hi = b;
    if (lo == hi) begin
      hue = 0;
      sat = 0;
    end else begin
      d = hi - lo;
      if (r == hi) hue = (g - b) * 100 / d;
      else if (g == hi) hue = 200 + (b - r) * 100 / d;
      else hue = 400 + (r - g) * 100 / d;
      hue = hue * 60 / 100;
      if (hue < 0) hue += 360;
      sat = d * 100 / hi;
    end
    val = hi;
    diff = hue - int'(c.target_hue);
    thr = int'(c.hue_threshold);
    return diff * diff < thr * thr && sat > int'(c.min_saturation) && val > int'(c.min_value);
  endfunction

  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    box_t        want, got;
    int unsigned fw, fh;
    if (rst) begin
      regs <= '{frame_width: 11'd320, frame_height: 11'd240, target_hue: 9'd0,
                min_saturation: 7'd0, min_value: 7'd0, hue_threshold: 9'd10};
      col = 0;
      row = 0;
      min_col = 320;
      min_row = 240;
      max_col = 0;
      max_row = 0;
      hits = 0;
      box_queue.delete();
      failures = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hcbb_pkg::REG_FRAME_WIDTH: regs.frame_width <= cfg_data;
          hcbb_pkg::REG_FRAME_HEIGHT: regs.frame_height <= cfg_data;
          hcbb_pkg::REG_TARGET_HUE: regs.target_hue <= cfg_data[8:0];
          hcbb_pkg::REG_MIN_SATURATION: regs.min_saturation <= cfg_data[6:0];
          hcbb_pkg::REG_MIN_VALUE: regs.min_value <= cfg_data[6:0];
          hcbb_pkg::REG_HUE_THRESHOLD: regs.hue_threshold <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fw = clamp_dim(regs.frame_width, LIMIT_W);
        fh = clamp_dim(regs.frame_height, LIMIT_H);
        if (col == 0 && row == 0) begin
          min_col = fw;
          min_row = fh;
          max_col = 0;
          max_row = 0;
          hits = 0;
        end
        if (pixel_matches(s_axis_tdata, regs)) begin
          hits++;
          if (col < min_col) min_col = col;
          if (row < min_row) min_row = row;
          if (col > max_col) max_col = col;
          if (row > max_row) max_row = row;
        end
        if (col + 1 >= fw) begin
          col = 0;
          if (row + 1 >= fh) begin
            row = 0;
            want.x = 11'(min_col);
            want.y = 11'(min_row);
            want.w = 11'(max_col - min_col);
            want.h = 11'(max_row - min_row);
            want.hits = hits;
            want.found = (hits != 0);
            box_queue.push_back(want);
            min_col = fw;
            min_row = fh;
            max_col = 0;
            max_row = 0;
            hits = 0;
          end else begin
            row = row + 1;
          end
        end else begin
          col = col + 1;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[10:0], m_axis_tdata[21:11], m_axis_tdata[32:22],
               m_axis_tdata[43:33], m_axis_tdata[64:44], m_axis_tuser};
        if (box_queue.size() == 0) begin
          failures++;
          $display("%0t: unexpected box beat, expected none, actual %h", $time, got);
        end else begin
          want = box_queue.pop_front();
          compare_field("box_x", want.x, got.x);
          compare_field("box_y", want.y, got.y);
          compare_field("box_w", want.w, got.w);
          compare_field("box_h", want.h, got.h);
          compare_field("match_count", want.hits, got.hits);
          compare_field("found", want.found, got.found);
        end
      end
    end
    boxes_pending = box_queue.size();
  end

endmodule

>>> test/hsv_color_blob_bounding_box_tb.sv
// Top testbench for the colour blob box block: drives pixels and register writes, gives the verdict.
module hsv_color_blob_bounding_box_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  int          failures;
  int          boxes_pending;
  int          pixels_sent = 0;
  bit          no_gaps = 0;
  int          stall_left = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  hsv_color_blob_bounding_box DUT (.*);

  hsv_color_blob_bounding_box_checker checker_i (.*);

  function automatic int gap_length();
    int p;
    p = $urandom_range(99);
    if (no_gaps || p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(3) != 0) || no_gaps;
      stall_left <= gap_length();
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [10:0] value);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send_pixel(input logic [15:0] word);
    int gap;
    gap = gap_length();
    repeat (gap) @(negedge clk);
    @(negedge clk);
    s_axis_tvalid <= 1;
    s_axis_tdata <= word;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid <= 0;
    pixels_sent++;
  endtask

  // A frame that is still open emits nothing, so allow the pipeline to drain fully.
  task automatic wait_idle();
    while (boxes_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_match(input logic [8:0] hue, input logic [6:0] sat, input logic [6:0] val,
                           input logic [8:0] thr);
    write_reg(hcbb_pkg::REG_TARGET_HUE, 11'(hue));
    write_reg(hcbb_pkg::REG_MIN_SATURATION, 11'(sat));
    write_reg(hcbb_pkg::REG_MIN_VALUE, 11'(val));
    write_reg(hcbb_pkg::REG_HUE_THRESHOLD, 11'(thr));
  endtask

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [15:0] directed[] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'hFFE0,
                                16'hF81F, 16'h07FF, 16'h8410, 16'hF820, 16'hF801, 16'h0821};
    int fw, fh, frames, count;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Default 320x240 frame left open, then shrunk so the column wraps past the new edge.
    foreach (directed[i]) if (i < 5) send_pixel(directed[i]);
    wait_idle();
    write_reg(hcbb_pkg::REG_FRAME_WIDTH, 11'd2);
    write_reg(hcbb_pkg::REG_FRAME_HEIGHT, 11'd1);
    send_pixel(16'hF800);

    // Zero sizes act as one pixel per frame, so every pixel yields a box.
    wait_idle();
    write_reg(hcbb_pkg::REG_FRAME_WIDTH, 11'd0);
    write_reg(hcbb_pkg::REG_FRAME_HEIGHT, 11'd0);
    set_match(9'd0, 7'd0, 7'd0, 9'd360);
    foreach (directed[i]) send_pixel(directed[i]);
    wait_idle();
    set_match(9'd511, 7'd127, 7'd127, 9'd511);
    send_pixel(16'hF800);
    send_pixel(16'hFFFF);
    wait_idle();
    set_match(9'd120, 7'd50, 7'd50, 9'd0);
    send_pixel(16'h07E0);

    // Oversized sizes clamp to the maximum; this frame stays open and is resized below.
    wait_idle();
    set_match(9'd0, 7'd10, 7'd10, 9'd30);
    write_reg(hcbb_pkg::REG_FRAME_WIDTH, 11'd2047);
    write_reg(hcbb_pkg::REG_FRAME_HEIGHT, 11'd2047);
    repeat (40) send_pixel(($urandom_range(3) == 0) ? 16'hF800 : 16'($urandom));

    while (pixels_sent < 950) begin
      wait_idle();
      no_gaps = ($urandom_range(4) == 0);
      fw = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(6);
      fh = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(6);
      if (fw > 40) fh = 1;
      write_reg(hcbb_pkg::REG_FRAME_WIDTH, 11'(fw));
      write_reg(hcbb_pkg::REG_FRAME_HEIGHT, 11'(fh));
      set_match(9'($urandom_range(($urandom_range(7) == 0) ? 511 : 359)),
                7'($urandom_range(($urandom_range(7) == 0) ? 127 : 60)),
                7'($urandom_range(($urandom_range(7) == 0) ? 127 : 60)),
                9'($urandom_range(($urandom_range(7) == 0) ? 511 : 120)));
      if (fw == 0) fw = 1;
      if (fw > 1024) fw = 1024;
      if (fh == 0) fh = 1;
      frames = $urandom_range(4, 1);
      count = frames * fw * fh;
      if ($urandom_range(5) == 0) count += $urandom_range(fw * fh);
      if (count > 120) count = 120;
      repeat (count) send_pixel(16'($urandom));
    end

    wait_idle();
    while (boxes_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
